/* hw/rtl/mdf_pkg.sv */
// ----------------------------------------------------------------------------
// mdf_pkg
// Shared types, constants and helpers of the demo message deframer.
// ----------------------------------------------------------------------------
package mdf_pkg;

    // Width of the internal saturating totals
    localparam int TOTAL_BITS   = 24;
    // Width of the reported totals
    localparam int OUT_BITS     = 24;

    localparam int FIXED_SIZE   = 10;
    localparam int MULTI_OFFSET = 6;
    localparam int PLAIN_OFFSET = 2;
    localparam int LENGTH_BYTES = 4;

    localparam logic [3:0] BODY_PHASE = 4'd15;

    localparam int CFG_IDX_BITS = 3;

    // Sum of a total and a 33-bit message size never needs more than this
    localparam int SUM_BITS  = 34;
    localparam int WIDE_BITS = 33;
    localparam logic [WIDE_BITS-1:0] OUT_MAX = (WIDE_BITS'(1) << OUT_BITS) - WIDE_BITS'(1);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BYTE_LIMIT = 3'd0,
        CFG_OVERSIZE   = 3'd1,
        CFG_TYPE_MASK  = 3'd2,
        CFG_FIXED_CODE = 3'd3,
        CFG_MULTI_CODE = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [23:0] byte_limit;
        logic [31:0] oversize_threshold;
        logic [7:0]  type_mask;
        logic [7:0]  fixed_type_code;
        logic [7:0]  multi_type_code;
    } cfg_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] complete_bytes;
        logic [OUT_BITS-1:0] time_total;
        logic                message_done;
        logic                limit_reached;
        logic                final_result;
        logic                length_warning;
    } res_t;

    function automatic logic [TOTAL_BITS-1:0] sat_add(
        input logic [TOTAL_BITS-1:0] a,
        input logic [32:0]           b
    );
        logic [SUM_BITS-1:0] s;
        s = SUM_BITS'(a) + SUM_BITS'(b);
        if (|s[SUM_BITS-1:TOTAL_BITS]) begin
            return '1;
        end
        return s[TOTAL_BITS-1:0];
    endfunction

    function automatic logic [OUT_BITS-1:0] out_sat(input logic [TOTAL_BITS-1:0] t);
        logic [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(t);
        if (w > OUT_MAX) begin
            return '1;
        end
        return w[OUT_BITS-1:0];
    endfunction

endpackage

/* hw/rtl/demo_message_deframer_unit.sv */
// ----------------------------------------------------------------------------
// demo_message_deframer_unit
// Frames demo stream messages and keeps saturating byte and time totals.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    tdata: data_byte; tuser: buffer_start;
//                                     tlast: buffer_end
//  m_*      out  m_tvalid/m_tready    tdata: complete_bytes, time_total;
//                                     tuser: done, limit, warning; tlast: final
//  cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One byte per cycle while s_tready is high; each result is registered before it is visible.
//  The framing state register closes the framing loop through combinational next-state logic.
//  Synchronous active-low reset clears framing state and totals and loads the config defaults.
//  A stalled result sits in the output register; one more result fits in the
//  skid entry, after which s_tready drops until the result side drains.
// ----------------------------------------------------------------------------
module demo_message_deframer_unit (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] data_byte
    input  logic                             s_tuser,   // [0] buffer_start
    input  logic                             s_tlast,   // buffer_end

    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [47:0]                      m_tdata,   // [23:0] complete_bytes,
                                                        // [47:24] time_total
    output logic [2:0]                       m_tuser,   // [0] message_done,
                                                        // [1] limit_reached,
                                                        // [2] length_warning
    output logic                             m_tlast,   // final_result

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mdf_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [31:0]                      cfg_data
);

    mdf_pkg::cfg_t cfg;
    mdf_pkg::res_t res;
    mdf_pkg::res_t out_res;
    logic          res_push;
    logic          can_push;
    logic          in_fire;

    assign cfg_ready = 1'b1;
    assign s_tready  = can_push;
    assign in_fire   = s_tvalid && s_tready;

    mdf_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mdf_frame_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .in_fire      (in_fire),
        .data_byte    (s_tdata),
        .buffer_start (s_tuser),
        .buffer_end   (s_tlast),
        .res_push     (res_push),
        .res          (res)
    );

    mdf_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res),
        .can_push  (can_push),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {out_res.time_total, out_res.complete_bytes};
    assign m_tuser = {out_res.length_warning, out_res.limit_reached, out_res.message_done};
    assign m_tlast = out_res.final_result;

    // input back-pressure only comes from a full skid entry
    a_stall_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // the last byte of a buffer always yields a result
    a_end_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("buffer end produced no result");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

/* hw/rtl/mdf_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mdf_cfg_regs
// Configuration register file, written through the config request channel.
// ----------------------------------------------------------------------------
module mdf_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_write,
    input  logic [mdf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [31:0]                       cfg_data,
    output mdf_pkg::cfg_t                     cfg
);

    mdf_pkg::cfg_t cfg_reg;
    mdf_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            unique case (cfg_index)
                mdf_pkg::CFG_BYTE_LIMIT: cfg_next.byte_limit         = cfg_data[23:0];
                mdf_pkg::CFG_OVERSIZE:   cfg_next.oversize_threshold = cfg_data;
                mdf_pkg::CFG_TYPE_MASK:  cfg_next.type_mask          = cfg_data[7:0];
                mdf_pkg::CFG_FIXED_CODE: cfg_next.fixed_type_code    = cfg_data[7:0];
                mdf_pkg::CFG_MULTI_CODE: cfg_next.multi_type_code    = cfg_data[7:0];
                default: ;  // writes past the list are dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.byte_limit         <= 24'd0;
            cfg_reg.oversize_threshold <= 32'd65536;
            cfg_reg.type_mask          <= 8'd7;
            cfg_reg.fixed_type_code    <= 8'd2;
            cfg_reg.multi_type_code    <= 8'd3;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/mdf_frame_core.sv */
// ----------------------------------------------------------------------------
// mdf_frame_core
// Framing state and totals; one byte is consumed per accepted request.
// ----------------------------------------------------------------------------
module mdf_frame_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  mdf_pkg::cfg_t cfg,
    input  logic          in_fire,
    input  logic [7:0]    data_byte,
    input  logic          buffer_start,
    input  logic          buffer_end,
    output logic          res_push,
    output mdf_pkg::res_t res
);

    typedef struct packed {
        logic [3:0]                     hdr_pos;
        logic [2:0]                     len_off;
        logic [31:0]                    len_gather;
        logic [31:0]                    bytes_left;
        logic [7:0]                     pend_time;
        logic [mdf_pkg::TOTAL_BITS-1:0] byte_total;
        logic [mdf_pkg::TOTAL_BITS-1:0] time_sum;
        logic                           stopped;
        logic                           warned;
    } state_t;

    state_t     st_reg;
    state_t     st_next;
    state_t     cur;
    state_t     n;
    logic       done;
    logic       fin;
    logic [7:0] typ;
    logic [1:0] k;
    logic [3:0] rel;
    logic [32:0] msg_size;

    always_comb begin
        // start mark clears everything before the byte is used
        cur  = buffer_start ? '0 : st_reg;
        n    = cur;
        fin  = 1'b0;
        done = 1'b0;
        typ  = data_byte & cfg.type_mask;
        rel  = cur.hdr_pos - {1'b0, cur.len_off};
        k    = rel[1:0];

        if (!cur.stopped) begin
            priority if (cur.hdr_pos == 4'd0) begin
                n.pend_time = data_byte;
                n.hdr_pos   = 4'd1;
            end else if (cur.hdr_pos == 4'd1) begin
                if (typ == cfg.fixed_type_code) begin
                    n.len_off    = 3'd0;
                    n.len_gather = 32'(mdf_pkg::FIXED_SIZE - mdf_pkg::LENGTH_BYTES);
                    n.bytes_left = 32'(mdf_pkg::FIXED_SIZE - 2);
                    n.hdr_pos    = mdf_pkg::BODY_PHASE;
                end else begin
                    n.len_off    = (typ == cfg.multi_type_code) ?
                                   3'(mdf_pkg::MULTI_OFFSET) : 3'(mdf_pkg::PLAIN_OFFSET);
                    n.len_gather = 32'd0;
                    n.hdr_pos    = 4'd2;
                end
            end else if (cur.hdr_pos == mdf_pkg::BODY_PHASE) begin
                if (cur.bytes_left != 32'd0) begin
                    n.bytes_left = cur.bytes_left - 32'd1;
                end
                if (n.bytes_left == 32'd0) begin
                    fin = 1'b1;
                end
            end else begin
                if (5'(cur.hdr_pos) >= 5'(cur.len_off)) begin
                    n.len_gather = cur.len_gather | (32'(data_byte) << {k, 3'b000});
                end
                if (5'(cur.hdr_pos) >= 5'(cur.len_off) + 5'd3) begin
                    if (n.len_gather > cfg.oversize_threshold) begin
                        n.warned = 1'b1;
                    end
                    n.bytes_left = n.len_gather;
                    if (n.len_gather == 32'd0) begin
                        fin = 1'b1;
                    end else begin
                        n.hdr_pos = mdf_pkg::BODY_PHASE;
                    end
                end else begin
                    n.hdr_pos = cur.hdr_pos + 4'd1;
                end
            end
        end

        msg_size = 33'(n.len_gather) + 33'(n.len_off) + 33'(mdf_pkg::LENGTH_BYTES);
        if (fin) begin
            done         = 1'b1;
            n.byte_total = mdf_pkg::sat_add(n.byte_total, msg_size);
            n.time_sum   = mdf_pkg::sat_add(n.time_sum, 33'(n.pend_time));
            n.hdr_pos    = 4'd0;
            n.len_off    = 3'd0;
            n.len_gather = 32'd0;
            n.bytes_left = 32'd0;
            n.pend_time  = 8'd0;
            if (cfg.byte_limit != 24'd0 &&
                33'(n.byte_total) >= 33'(cfg.byte_limit)) begin
                n.stopped = 1'b1;
            end
        end

        res.complete_bytes = mdf_pkg::out_sat(n.byte_total);
        res.time_total     = mdf_pkg::out_sat(n.time_sum);
        res.message_done   = done;
        res.limit_reached  = n.stopped;
        res.final_result   = buffer_end;
        res.length_warning = n.warned;

        res_push = in_fire && (done || buffer_end);

        if (in_fire) begin
            st_next = buffer_end ? '0 : n;
        end else begin
            st_next = st_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else begin
            st_reg <= st_next;
        end
    end

endmodule

/* hw/rtl/mdf_out_skid.sv */
// ----------------------------------------------------------------------------
// mdf_out_skid
// Result register with one skid entry behind it.
// ----------------------------------------------------------------------------
module mdf_out_skid (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mdf_pkg::res_t push_data,
    output logic          can_push,
    output logic          out_valid,
    input  logic          out_ready,
    output mdf_pkg::res_t out_data
);

    logic          out_valid_reg;
    logic          skid_valid_reg;
    mdf_pkg::res_t out_reg;
    mdf_pkg::res_t skid_reg;
    logic          pop;

    assign pop = out_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (push) begin
                // push is only offered while the skid entry is free
                if (!out_valid_reg || pop) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (pop) begin
                if (skid_valid_reg) begin
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            if (!out_valid_reg || pop) begin
                out_reg <= push_data;
            end else begin
                skid_reg <= push_data;
            end
        end else if (pop && skid_valid_reg) begin
            out_reg <= skid_reg;
        end
    end

    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
